/* sv/sps_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sps_pkg: shared types and constants
// Request and event codes, datapath command set and field widths for the
// speed profile sequencer.
// ---------------------------------------------------------------------------
package sps_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int TIME_W    = 32;
	localparam int SPEED_W   = 24;
	localparam int TUS_W     = 42;
	localparam int FREQ_W    = 24;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 20;
	localparam int DEB_W     = 20;
	localparam int REP_W     = 16;
	localparam int CODE_W    = 4;
	localparam int ROW_OUT_W = 8;
	localparam int ROWS_W    = 9;
	localparam int MAG_W     = 24;
	localparam int PROD_W    = 56;
	localparam int ENTRY_W   = TIME_W + SPEED_W;

	localparam logic [9:0]        MS_TO_US = 10'd1000;
	localparam logic [FREQ_W-1:0] FREQ_MIN = 24'd16;
	localparam logic [FREQ_W-1:0] FREQ_MAX = 24'hFFFFFF;

	localparam logic [31:0]       PPC_RST   = 32'd8355283;
	localparam logic [STEP_W-1:0] STEP_RST  = 20'd10000;
	localparam logic [31:0]       LIMIT_RST = 32'd1000000;
	localparam logic [REP_W-1:0]  REPS_RST  = 16'd0;
	localparam logic [DEB_W-1:0]  DEB_RST   = 20'd50000;

	typedef enum logic [2:0] {
		REQ_BEGIN, REQ_ROW, REQ_END, REQ_START, REQ_STOP, REQ_TICK, REQ_UPPER, REQ_LOWER
	} req_t;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE, EV_ACK, EV_UPDATE, EV_RESTART, EV_DONE_REPS, EV_DONE_TIMEOUT,
		EV_UPPER, EV_LOWER, EV_STOPPED, EV_NOT_RUNNING, EV_NO_TABLE, EV_FULL,
		EV_SW_IGNORED
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PPC, CFG_STEP, CFG_LIMIT, CFG_REPS, CFG_DEB
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SIMPLE, OP_NOSTART, OP_TICK_BEGIN, OP_WALK_RD,
		OP_WALK_MUL, OP_WALK_CMP, OP_I_RD0, OP_I_RD1, OP_I_RD2, OP_I_PREP,
		OP_I_MUL, OP_DIV_GO, OP_DIV_END, OP_START_RD, OP_START_SET, OP_FREQ,
		OP_FREQ2, OP_TICK_END
	} dp_op_t;

	typedef struct packed {
		req_t req;
		logic usable;
		logic start_ok;
		logic has_next;
		logic walk_adv;
		logic need_div;
		logic div_done;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_START_SET, S_WALK, S_WALK_MUL, S_WALK_CMP, S_I_RD1,
		S_I_RD2, S_I_PREP, S_I_MUL, S_DIV_GO, S_DIV_WAIT, S_FREQ, S_FREQ2,
		S_TICK_END, S_DONE
	} ctrl_state_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

endpackage
`default_nettype wire

/* sv/sps_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sps_div: restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits QUO_W.
// ---------------------------------------------------------------------------
module sps_div #(
	parameter int DVD_W = 56,
	parameter int DVS_W = 42,
	parameter int QUO_W = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [QUO_W-1:0] quotient
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] den_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, num_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= DVS_W'(dividend >> QUO_W);
			num_q <= dividend[QUO_W-1:0];
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, den_q}) : DVS_W'(trial);
			num_q <= num_q << 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* sv/sps_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sps_dp: sequencer datapath
// Profile table memory, run state, config registers, interpolation and
// pulse frequency arithmetic, driven one command per cycle.
// ---------------------------------------------------------------------------
module sps_dp #(
	parameter int TABLE_DEPTH = sps_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire sps_pkg::dp_op_t                      op,
	output sps_pkg::dp_stat_t                         stat,
	input  wire logic [2:0]                           req_type,
	input  wire logic [sps_pkg::TIME_W-1:0]           row_time_ms,
	input  wire logic signed [sps_pkg::SPEED_W-1:0]   row_speed,
	input  wire logic                                 cfg_we,
	input  wire logic [sps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sps_pkg::CFG_W-1:0]            cfg_wdata,
	output logic [sps_pkg::CODE_W-1:0]                event_code,
	output logic [sps_pkg::ROW_OUT_W-1:0]             row_index,
	output logic signed [sps_pkg::SPEED_W-1:0]        speed_cmd,
	output logic [sps_pkg::FREQ_W-1:0]                pulse_freq,
	output logic                                      direction_up,
	output logic                                      motor_enabled,
	output logic [sps_pkg::ROWS_W-1:0]                rows_stored,
	output logic [sps_pkg::REP_W-1:0]                 runs_remaining
);
	import sps_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

	// config
	logic [31:0]       ppc_q;
	logic [STEP_W-1:0] step_q;
	logic [31:0]       limit_q;
	logic [REP_W-1:0]  reps_q;
	logic [DEB_W-1:0]  deb_q;

	// run state
	logic [LW-1:0]    len_q;
	logic             ready_q;
	logic             run_q;
	logic [AW-1:0]    row_q;
	logic [31:0]      elapsed_q;
	logic [REP_W-1:0] runs_left_q;
	logic             drive_q;
	logic [31:0]      upper_q;
	logic [31:0]      lower_q;

	// work registers
	req_t               req_q;
	logic [TIME_W-1:0]  rtime_q;
	logic [SPEED_W-1:0] rspeed_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [TUS_W-1:0]   tmul_q;
	logic [TUS_W-1:0]   t0_q;
	logic [TUS_W-1:0]   t1_q;
	logic [SPEED_W-1:0] v0_q;
	logic [SPEED_W-1:0] v1_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic [31:0]        et0_q;
	logic [TUS_W-1:0]   dt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  fprod_q;
	logic [SPEED_W-1:0] spd_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [AW-1:0]      row_out_q;
	event_t             code_q;

	logic [TIME_W-1:0]  rd_time;
	logic [SPEED_W-1:0] rd_speed;
	logic [TUS_W-1:0]   tus;
	logic [TUS_W-1:0]   e42;
	logic [AW-1:0]      row_inc;
	logic               has_next;
	logic               usable;
	logic               full;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic               use_v0;
	logic               use_v1;
	logic [SPEED_W:0]   dspd;
	logic [SPEED_W-1:0] spd_abs;
	logic [33:0]        fsh;
	logic [31:0]        sw_quiet;
	logic               sw_ok;
	event_t             simple_code;
	logic               end_hit;
	logic [REP_W-1:0]   rl_next;
	logic               stop_run;
	event_t             tick_code;
	logic               div_done;
	logic [MAG_W-1:0]   quo;

	assign rd_time  = rd_q[ENTRY_W-1:SPEED_W];
	assign rd_speed = rd_q[SPEED_W-1:0];
	assign tus      = TUS_W'(rd_time) * TUS_W'(MS_TO_US);
	assign e42      = TUS_W'(elapsed_q);
	assign row_inc  = row_q + 1'b1;
	assign has_next = ((LW+1)'(row_q) + 1'b1) < (LW+1)'(len_q);
	assign usable   = run_q && ready_q && (len_q != '0);
	assign full     = len_q >= LW'(TABLE_DEPTH);

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = row_q;
		case (op)
			OP_START_RD:            rd_addr = '0;
			OP_WALK_RD, OP_I_RD1:   rd_addr = row_inc;
			OP_I_RD0, OP_WALK_CMP:  rd_addr = row_q;
			default:                rd_en   = 1'b0;
		endcase
	end

	assign wr_en = (op == OP_SIMPLE) && (req_q == REQ_ROW) && !full;

	always_ff @(posedge clk) begin
		if (wr_en) mem[len_q[AW-1:0]] <= {rtime_q, rspeed_q};
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// interpolation selection
	assign use_v0  = !has_next || (t1_q <= t0_q) || (e42 <= t0_q);
	assign use_v1  = !use_v0 && (e42 >= t1_q);
	assign dspd    = {v1_q[SPEED_W-1], v1_q} - {v0_q[SPEED_W-1], v0_q};
	assign spd_abs = spd_q[SPEED_W-1] ? (~spd_q + 1'b1) : spd_q;
	assign fsh     = fprod_q[PROD_W-1:22];

	always_comb begin
		sw_quiet = (req_q == REQ_UPPER) ? upper_q : lower_q;
		sw_ok    = drive_q && (sw_quiet > {12'b0, deb_q});
		case (req_q)
			REQ_BEGIN, REQ_END: simple_code = EV_ACK;
			REQ_ROW:   simple_code = full ? EV_FULL : EV_ACK;
			REQ_STOP:  simple_code = run_q ? EV_STOPPED : EV_NOT_RUNNING;
			REQ_UPPER: simple_code = sw_ok ? EV_UPPER : EV_SW_IGNORED;
			REQ_LOWER: simple_code = sw_ok ? EV_LOWER : EV_SW_IGNORED;
			default:   simple_code = EV_NONE;
		endcase
	end

	always_comb begin
		end_hit  = !has_next && (e42 >= t0_q);
		rl_next  = (runs_left_q != '0) ? runs_left_q - 1'b1 : '0;
		stop_run = (rl_next == '0) || (elapsed_q >= limit_q);
		if (!end_hit)
			tick_code = EV_UPDATE;
		else if (rl_next == '0)
			tick_code = EV_DONE_REPS;
		else if (elapsed_q >= limit_q)
			tick_code = EV_DONE_TIMEOUT;
		else
			tick_code = EV_RESTART;
	end

	sps_div #(
		.DVD_W(PROD_W),
		.DVS_W(TUS_W),
		.QUO_W(MAG_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (op == OP_DIV_GO),
		.dividend(prod_q),
		.divisor (dt_q),
		.done    (div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppc_q       <= PPC_RST;
			step_q      <= STEP_RST;
			limit_q     <= LIMIT_RST;
			reps_q      <= REPS_RST;
			deb_q       <= DEB_RST;
			len_q       <= '0;
			ready_q     <= 1'b0;
			run_q       <= 1'b0;
			row_q       <= '0;
			elapsed_q   <= '0;
			runs_left_q <= '0;
			drive_q     <= 1'b0;
			upper_q     <= '0;
			lower_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PPC:   ppc_q   <= cfg_wdata;
					CFG_STEP:  step_q  <= cfg_wdata[STEP_W-1:0];
					CFG_LIMIT: limit_q <= cfg_wdata;
					CFG_REPS:  reps_q  <= cfg_wdata[REP_W-1:0];
					CFG_DEB:   deb_q   <= cfg_wdata[DEB_W-1:0];
					default: ;
				endcase
			end
			case (op)
				OP_SIMPLE: begin
					case (req_q)
						REQ_BEGIN: begin
							len_q   <= '0;
							ready_q <= 1'b0;
						end
						REQ_ROW:   if (!full) len_q <= len_q + 1'b1;
						REQ_END:   ready_q <= 1'b1;
						REQ_STOP: begin
							if (run_q) begin
								run_q       <= 1'b0;
								drive_q     <= 1'b0;
								runs_left_q <= '0;
							end
						end
						REQ_UPPER, REQ_LOWER: begin
							if (sw_ok) begin
								drive_q <= 1'b0;
								run_q   <= 1'b0;
								if (req_q == REQ_UPPER) upper_q <= '0;
								else lower_q <= '0;
							end
						end
						default: ;
					endcase
				end
				OP_TICK_BEGIN: begin
					upper_q <= sat_add32(upper_q, 32'(step_q));
					lower_q <= sat_add32(lower_q, 32'(step_q));
					if (usable) begin
						// table may have shrunk under the run
						if (LW'(row_q) >= len_q) row_q <= AW'(len_q - 1'b1);
						elapsed_q <= sat_add32(elapsed_q, 32'(step_q));
					end
				end
				OP_WALK_CMP: if (tmul_q <= e42) row_q <= row_inc;
				OP_START_SET: begin
					runs_left_q <= (reps_q == '0) ? REP_W'(1) : reps_q;
					upper_q     <= '0;
					lower_q     <= '0;
					run_q       <= 1'b1;
					row_q       <= '0;
					elapsed_q   <= '0;
					if (rd_speed != '0) drive_q <= 1'b1;
				end
				OP_TICK_END: begin
					drive_q <= 1'b1;
					if (end_hit) begin
						runs_left_q <= rl_next;
						if (stop_run) begin
							drive_q <= 1'b0;
							run_q   <= 1'b0;
						end else begin
							row_q     <= '0;
							elapsed_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				req_q    <= req_t'(req_type);
				rtime_q  <= row_time_ms;
				rspeed_q <= row_speed;
			end
			OP_SIMPLE, OP_NOSTART: begin
				spd_q     <= '0;
				freq_q    <= FREQ_MIN;
				row_out_q <= row_q;
				code_q    <= (op == OP_NOSTART) ? EV_NO_TABLE : simple_code;
			end
			OP_TICK_BEGIN: begin
				if (!usable) begin
					spd_q     <= '0;
					freq_q    <= FREQ_MIN;
					row_out_q <= row_q;
					code_q    <= EV_NONE;
				end
			end
			OP_WALK_MUL: tmul_q <= tus;
			OP_I_RD1: begin
				v0_q <= rd_speed;
				t0_q <= tus;
			end
			OP_I_RD2: begin
				v1_q <= rd_speed;
				t1_q <= tus;
			end
			OP_I_PREP: begin
				neg_q <= dspd[SPEED_W];
				mag_q <= MAG_W'(dspd[SPEED_W] ? -dspd : dspd);
				et0_q <= 32'(e42 - t0_q);
				dt_q  <= t1_q - t0_q;
				spd_q <= use_v0 ? v0_q : v1_q;
			end
			OP_I_MUL:   prod_q <= PROD_W'(mag_q) * PROD_W'(et0_q);
			OP_DIV_END: spd_q  <= neg_q ? (v0_q - quo) : (v0_q + quo);
			OP_START_SET: begin
				spd_q     <= rd_speed;
				row_out_q <= '0;
				code_q    <= EV_ACK;
			end
			OP_FREQ:  fprod_q <= PROD_W'(spd_abs) * PROD_W'(ppc_q);
			OP_FREQ2: begin
				if (fsh < 34'(FREQ_MIN))      freq_q <= FREQ_MIN;
				else if (fsh > 34'(FREQ_MAX)) freq_q <= FREQ_MAX;
				else                          freq_q <= fsh[FREQ_W-1:0];
			end
			OP_TICK_END: begin
				row_out_q <= row_q;
				code_q    <= tick_code;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.req      = req_q;
		stat.usable   = usable;
		stat.start_ok = ready_q && (len_q != '0);
		stat.has_next = has_next;
		stat.walk_adv = tmul_q <= e42;
		stat.need_div = !use_v0 && !use_v1;
		stat.div_done = div_done;
	end

	assign event_code     = code_q;
	assign row_index      = ROW_OUT_W'(row_out_q);
	assign speed_cmd      = spd_q;
	assign pulse_freq     = freq_q;
	assign direction_up   = !spd_q[SPEED_W-1];
	assign motor_enabled  = drive_q;
	assign rows_stored    = ROWS_W'(len_q);
	assign runs_remaining = runs_left_q;
endmodule
`default_nettype wire

/* sv/sps_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sps_ctrl: sequencer controller
// Walks each accepted item through the datapath commands it needs.
// ---------------------------------------------------------------------------
module sps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire sps_pkg::dp_stat_t stat,
	output sps_pkg::dp_op_t        op
);
	import sps_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (start) state_d = S_EXEC;
			S_EXEC: begin
				case (stat.req)
					REQ_TICK:  state_d = stat.usable ? S_WALK : S_DONE;
					REQ_START: state_d = stat.start_ok ? S_START_SET : S_DONE;
					default:   state_d = S_DONE;
				endcase
			end
			S_START_SET: state_d = S_FREQ;
			S_WALK:      state_d = stat.has_next ? S_WALK_MUL : S_I_RD1;
			S_WALK_MUL:  state_d = S_WALK_CMP;
			S_WALK_CMP:  state_d = stat.walk_adv ? S_WALK : S_I_RD1;
			S_I_RD1:     state_d = S_I_RD2;
			S_I_RD2:     state_d = S_I_PREP;
			S_I_PREP:    state_d = stat.need_div ? S_I_MUL : S_FREQ;
			S_I_MUL:     state_d = S_DIV_GO;
			S_DIV_GO:    state_d = S_DIV_WAIT;
			S_DIV_WAIT:  if (stat.div_done) state_d = S_FREQ;
			S_FREQ:      state_d = S_FREQ2;
			S_FREQ2:     state_d = (stat.req == REQ_TICK) ? S_TICK_END : S_DONE;
			S_TICK_END:  state_d = S_DONE;
			S_DONE:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		case (state_q)
			S_IDLE:      if (start) op = OP_LOAD;
			S_EXEC: begin
				case (stat.req)
					REQ_TICK:  op = OP_TICK_BEGIN;
					REQ_START: op = stat.start_ok ? OP_START_RD : OP_NOSTART;
					default:   op = OP_SIMPLE;
				endcase
			end
			S_START_SET: op = OP_START_SET;
			// advance past reached rows, else fetch the current row
			S_WALK:      op = stat.has_next ? OP_WALK_RD : OP_I_RD0;
			S_WALK_MUL:  op = OP_WALK_MUL;
			S_WALK_CMP:  op = OP_WALK_CMP;
			S_I_RD1:     op = OP_I_RD1;
			S_I_RD2:     op = OP_I_RD2;
			S_I_PREP:    op = OP_I_PREP;
			S_I_MUL:     op = OP_I_MUL;
			S_DIV_GO:    op = OP_DIV_GO;
			S_DIV_WAIT:  if (stat.div_done) op = OP_DIV_END;
			S_FREQ:      op = OP_FREQ;
			S_FREQ2:     op = OP_FREQ2;
			S_TICK_END:  op = OP_TICK_END;
			default:     op = OP_NONE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");
	a_start_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START_SET) |-> (stat.req == REQ_START))
		else $error("start sequence entered for another request");
	a_div_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_WAIT) |-> (stat.req == REQ_TICK))
		else $error("divider wait outside a tick");
endmodule
`default_nettype wire

/* sv/speed_profile_sequencer_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// speed_profile_sequencer_unit: piecewise-linear speed profile sequencer
// Loads a time/speed table and plays it back tick by tick as target speed,
// direction and drive pulse frequency.
// ---------------------------------------------------------------------------
// Usage:
//   Present an item on req_type/row_time_ms/row_speed and raise start; it is
//   taken at a clock edge with start high and busy low. One result per item
//   appears on the result ports for a single cycle with done high; there is
//   no backpressure, so capture it then.
//   Table and control items go straight from acceptance to done. A start
//   reads the first table row, sets up the run and computes the pulse
//   frequency. A tick goes straight to done when no run is active; else it
//   walks past each table row already reached, reads the current and next
//   rows, interpolates the speed (in the bit-serial divider when it falls
//   between two rows), computes the pulse frequency and updates the run
//   state. Row walking and the divider set how long a tick takes.
//   The cfg_we/cfg_index/cfg_wdata port writes a register at a clock edge
//   with cfg_we high; write only while busy is low.
//   After reset the table is empty, no run is active and the drive is off;
//   config registers hold their defaults. Table contents are not cleared.
// ---------------------------------------------------------------------------
module speed_profile_sequencer_unit #(
	parameter int TABLE_DEPTH = sps_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [2:0]                           req_type,
	input  wire logic [sps_pkg::TIME_W-1:0]           row_time_ms,
	input  wire logic signed [sps_pkg::SPEED_W-1:0]   row_speed,
	input  wire logic                                 cfg_we,
	input  wire logic [sps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sps_pkg::CFG_W-1:0]            cfg_wdata,
	output logic                                      done,
	output logic [sps_pkg::CODE_W-1:0]                event_code,
	output logic [sps_pkg::ROW_OUT_W-1:0]             row_index,
	output logic signed [sps_pkg::SPEED_W-1:0]        speed_cmd,
	output logic [sps_pkg::FREQ_W-1:0]                pulse_freq,
	output logic                                      direction_up,
	output logic                                      motor_enabled,
	output logic [sps_pkg::ROWS_W-1:0]                rows_stored,
	output logic [sps_pkg::REP_W-1:0]                 runs_remaining
);
	import sps_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	sps_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.stat  (stat),
		.op    (op)
	);

	sps_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.stat          (stat),
		.req_type      (req_type),
		.row_time_ms   (row_time_ms),
		.row_speed     (row_speed),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.event_code    (event_code),
		.row_index     (row_index),
		.speed_cmd     (speed_cmd),
		.pulse_freq    (pulse_freq),
		.direction_up  (direction_up),
		.motor_enabled (motor_enabled),
		.rows_stored   (rows_stored),
		.runs_remaining(runs_remaining)
	);
endmodule
`default_nettype wire
